/* hdl/pmfd_pkg.sv */
`default_nettype none

package pmfd_pkg;

   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 5;
   localparam int WORD_W   = 24;
   localparam int VALUE_W  = 32;
   localparam int PROD_W   = WORD_W + VALUE_W;
   localparam int QTY_COUNT = 3;
   localparam int QTY_W    = 2;
   localparam int CSR_INDEX_W = 2;

   // The six captured words are kept as one shift line of frame bytes.
   localparam int CAPTURE_W  = 2 * QTY_COUNT * WORD_W;

   // Byte positions inside a frame.
   localparam logic [INDEX_W-1:0] SUM_FIRST   = 5'd2;
   localparam logic [INDEX_W-1:0] WORD_FIRST  = 5'd3;
   localparam logic [INDEX_W-1:0] WORD_LAST   = 5'd20;
   localparam logic [INDEX_W-1:0] SUM_LAST    = 5'd22;
   localparam logic [INDEX_W-1:0] CHECK_INDEX = 5'd23;
   localparam logic [INDEX_W-1:0] IDLE_INDEX  = 5'd24;

   // Quantity slots, in output order.
   localparam logic [QTY_W-1:0] QTY_VOLTAGE = 2'd0;
   localparam logic [QTY_W-1:0] QTY_CURRENT = 2'd1;
   localparam logic [QTY_W-1:0] QTY_POWER   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLTAGE_COEFF = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_COEFF = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_COEFF   = 2'd2;

   localparam logic [VALUE_W-1:0] COEFF_RESET = 32'h0001_0000;
   localparam logic [VALUE_W-1:0] VALUE_SAT   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic                               status;
      logic [QTY_COUNT-1:0][WORD_W-1:0]   param;
      logic [QTY_COUNT-1:0][WORD_W-1:0]   raw;
   } job_type;

   typedef struct packed {
      logic busy;
   } bk_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_CHECK,
      BK_DIV,
      BK_NEXT,
      BK_OUT
   } bk_state_type;

endpackage

`default_nettype wire

/* hdl/pmfd_front.sv */
`default_nettype none

module pmfd_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [pmfd_pkg::BYTE_W-1:0]     req_rx_byte,
   input  wire logic                            req_frame_start,
   input  wire logic                            queue_full,
   output logic                                 push,
   output pmfd_pkg::job_type                    job
);

   logic [pmfd_pkg::INDEX_W-1:0]   byte_index_ff, byte_index_in;
   logic [pmfd_pkg::BYTE_W-1:0]    running_sum_ff, running_sum_in;
   logic [pmfd_pkg::CAPTURE_W-1:0] capture_ff, capture_in;
   logic [pmfd_pkg::INDEX_W-1:0]   idx;
   logic                           accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      idx            = req_frame_start ? '0 : byte_index_ff;
      byte_index_in  = byte_index_ff;
      running_sum_in = running_sum_ff;
      capture_in     = capture_ff;
      push           = 1'b0;

      if (accept) begin
         if (idx == '0) begin
            running_sum_in = '0;
         end
         if (idx >= pmfd_pkg::SUM_FIRST && idx <= pmfd_pkg::SUM_LAST) begin
            running_sum_in = running_sum_ff + req_rx_byte;
         end
         // Each captured byte enters at the top, so after the last word byte the
         // first one sits lowest and every word reads out low byte first.
         if (idx >= pmfd_pkg::WORD_FIRST && idx <= pmfd_pkg::WORD_LAST) begin
            capture_in = {req_rx_byte, capture_ff[pmfd_pkg::CAPTURE_W-1:pmfd_pkg::BYTE_W]};
         end
         if (idx == pmfd_pkg::CHECK_INDEX) begin
            push = 1'b1;
         end
         byte_index_in = (idx < pmfd_pkg::IDLE_INDEX) ? idx + 5'd1 : pmfd_pkg::IDLE_INDEX;
      end
   end

   always_comb begin
      job.status = (running_sum_ff != req_rx_byte);
      for (int q = 0; q < pmfd_pkg::QTY_COUNT; q++) begin
         job.param[q] = capture_ff[2*q*pmfd_pkg::WORD_W +: pmfd_pkg::WORD_W];
         job.raw[q]   = capture_ff[(2*q+1)*pmfd_pkg::WORD_W +: pmfd_pkg::WORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= '0;
         running_sum_ff <= '0;
      end else begin
         byte_index_ff  <= byte_index_in;
         running_sum_ff <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      capture_ff <= capture_in;
   end

endmodule

`default_nettype wire

/* hdl/pmfd_queue.sv */
`default_nettype none

module pmfd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire pmfd_pkg::job_type  push_job,
   output logic                    full,
   input  wire logic               pop,
   output pmfd_pkg::job_type       pop_job,
   output logic                    empty
);

   localparam int DEPTH = 2;

   pmfd_pkg::job_type entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* hdl/pmfd_back.sv */
`default_nettype none

module pmfd_back (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic [pmfd_pkg::QTY_COUNT-1:0][pmfd_pkg::VALUE_W-1:0] coeff,
   input  wire pmfd_pkg::job_type                                 queue_job,
   input  wire logic                                              queue_empty,
   output logic                                                   queue_pop,
   output pmfd_pkg::bk_status_type                                status,
   output logic                                                   rsp_valid,
   input  wire logic                                              rsp_stall,
   output logic                                                   rsp_frame_status,
   output logic [pmfd_pkg::VALUE_W-1:0]                           rsp_voltage_value,
   output logic [pmfd_pkg::VALUE_W-1:0]                           rsp_current_value,
   output logic [pmfd_pkg::VALUE_W-1:0]                           rsp_power_value
);

   localparam logic [4:0] DIV_LAST = 5'(pmfd_pkg::VALUE_W - 1);

   pmfd_pkg::bk_state_type state_ff, state_in;
   logic [pmfd_pkg::QTY_W-1:0]   qty_ff, qty_in;
   logic [4:0]                   step_ff, step_in;
   pmfd_pkg::job_type            job_ff, job_in;
   logic [pmfd_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [pmfd_pkg::WORD_W-1:0]  rem_ff, rem_in;
   logic [pmfd_pkg::VALUE_W-1:0] quo_ff, quo_in;
   logic [pmfd_pkg::QTY_COUNT-1:0][pmfd_pkg::VALUE_W-1:0] res_ff, res_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_status_ff;
   logic [pmfd_pkg::QTY_COUNT-1:0][pmfd_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                         load_out;

   logic [pmfd_pkg::WORD_W-1:0]  param_sel;
   logic [pmfd_pkg::WORD_W-1:0]  raw_sel;
   logic [pmfd_pkg::VALUE_W-1:0] coeff_sel;
   logic [pmfd_pkg::WORD_W:0]    trial;
   logic [pmfd_pkg::WORD_W:0]    diff;
   logic                         fits;

   assign param_sel = job_ff.param[qty_ff];
   assign raw_sel   = job_ff.raw[qty_ff];
   assign coeff_sel = coeff[qty_ff];

   // One restoring division step: bring down the next dividend bit and
   // subtract the divisor where it fits.
   assign trial = {rem_ff, quo_ff[pmfd_pkg::VALUE_W-1]};
   assign diff  = trial - {1'b0, raw_sel};
   assign fits  = (trial >= {1'b0, raw_sel});

   always_comb begin
      state_in  = state_ff;
      qty_in    = qty_ff;
      step_in   = step_ff;
      job_in    = job_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      res_in    = res_ff;
      queue_pop = 1'b0;
      load_out  = 1'b0;

      unique case (state_ff)
         pmfd_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               job_in    = queue_job;
               qty_in    = pmfd_pkg::QTY_VOLTAGE;
               if (queue_job.status) begin
                  res_in   = '0;
                  state_in = pmfd_pkg::BK_OUT;
               end else begin
                  state_in = pmfd_pkg::BK_MUL;
               end
            end
         end
         pmfd_pkg::BK_MUL: begin
            prod_in  = pmfd_pkg::PROD_W'(param_sel) * pmfd_pkg::PROD_W'(coeff_sel);
            state_in = pmfd_pkg::BK_CHECK;
         end
         pmfd_pkg::BK_CHECK: begin
            // The quotient exceeds 32 bits exactly when the upper product part
            // is not below the divisor.
            if (raw_sel == '0) begin
               res_in[qty_ff] = '0;
               state_in       = pmfd_pkg::BK_NEXT;
            end else if (prod_ff[pmfd_pkg::PROD_W-1:pmfd_pkg::VALUE_W] >= raw_sel) begin
               res_in[qty_ff] = pmfd_pkg::VALUE_SAT;
               state_in       = pmfd_pkg::BK_NEXT;
            end else begin
               rem_in   = prod_ff[pmfd_pkg::PROD_W-1:pmfd_pkg::VALUE_W];
               quo_in   = prod_ff[pmfd_pkg::VALUE_W-1:0];
               step_in  = '0;
               state_in = pmfd_pkg::BK_DIV;
            end
         end
         pmfd_pkg::BK_DIV: begin
            rem_in  = fits ? diff[pmfd_pkg::WORD_W-1:0] : trial[pmfd_pkg::WORD_W-1:0];
            quo_in  = {quo_ff[pmfd_pkg::VALUE_W-2:0], fits};
            step_in = step_ff + 5'd1;
            if (step_ff == DIV_LAST) begin
               res_in[qty_ff] = quo_in;
               state_in       = pmfd_pkg::BK_NEXT;
            end
         end
         pmfd_pkg::BK_NEXT: begin
            if (qty_ff == pmfd_pkg::QTY_POWER) begin
               state_in = pmfd_pkg::BK_OUT;
            end else begin
               qty_in   = qty_ff + 2'd1;
               state_in = pmfd_pkg::BK_MUL;
            end
         end
         pmfd_pkg::BK_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = pmfd_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = pmfd_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmfd_pkg::BK_IDLE;
         qty_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qty_ff       <= qty_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
      if (load_out) begin
         rsp_status_ff <= job_ff.status;
         rsp_value_ff  <= res_ff;
      end
   end

   assign status.busy       = (state_ff != pmfd_pkg::BK_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_status  = rsp_status_ff;
   assign rsp_voltage_value = rsp_value_ff[pmfd_pkg::QTY_VOLTAGE];
   assign rsp_current_value = rsp_value_ff[pmfd_pkg::QTY_CURRENT];
   assign rsp_power_value   = rsp_value_ff[pmfd_pkg::QTY_POWER];

endmodule

`default_nettype wire

/* hdl/power_meter_frame_decoder.sv */
// Energy-meter frame decoder.
// The request channel carries one frame byte per transfer with a start flag
// that marks byte 0; a byte is taken every cycle while the job queue has room.
// Bytes 2 to 22 are summed modulo 256 and bytes 3 to 20 are captured as six
// 24-bit words. Byte 23 closes the frame and queues one job; later bytes
// without a start flag are dropped and give nothing.
// The back end pops a job and computes voltage, current and power, each as
// param times coefficient over raw in unsigned 16.16, using one 24x32
// multiplier and a shared one-bit-per-cycle divider. A quantity skips the
// division when raw is zero or the result saturates; a checksum mismatch
// answers with status 1 and zero values.
// The response channel holds its transfer in an output register. While it is
// stalled the back end waits with its next result, the two-entry job queue
// fills, and then the request channel stalls.
// Reset clears the byte count, the sum, the queue and the response valid, and
// sets all three coefficients to 1.0. Coefficients are written on the csr
// port at any cycle and take effect for every later multiply, even mid-frame.
`default_nettype none

module power_meter_frame_decoder (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [7:0]                             req_rx_byte,
   input  wire logic                                   req_frame_start,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_frame_status,
   output logic [31:0]                                 rsp_voltage_value,
   output logic [31:0]                                 rsp_current_value,
   output logic [31:0]                                 rsp_power_value,
   input  wire logic                                   csr_wr_en,
   input  wire logic [pmfd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [31:0]                            csr_wr_data
);

   logic [pmfd_pkg::QTY_COUNT-1:0][pmfd_pkg::VALUE_W-1:0] coeff_ff;
   pmfd_pkg::job_type       front_job;
   pmfd_pkg::job_type       queue_job;
   pmfd_pkg::bk_status_type bk_status;
   logic                    front_push;
   logic                    queue_full;
   logic                    queue_empty;
   logic                    queue_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= {pmfd_pkg::QTY_COUNT{pmfd_pkg::COEFF_RESET}};
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pmfd_pkg::CSR_VOLTAGE_COEFF: coeff_ff[pmfd_pkg::QTY_VOLTAGE] <= csr_wr_data;
            pmfd_pkg::CSR_CURRENT_COEFF: coeff_ff[pmfd_pkg::QTY_CURRENT] <= csr_wr_data;
            pmfd_pkg::CSR_POWER_COEFF:   coeff_ff[pmfd_pkg::QTY_POWER]   <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   pmfd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .queue_full      (queue_full),
      .push            (front_push),
      .job             (front_job)
   );

   pmfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_job (front_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .pop_job  (queue_job),
      .empty    (queue_empty)
   );

   pmfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .coeff             (coeff_ff),
      .queue_job         (queue_job),
      .queue_empty       (queue_empty),
      .queue_pop         (queue_pop),
      .status            (bk_status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_voltage_value (rsp_voltage_value),
      .rsp_current_value (rsp_current_value),
      .rsp_power_value   (rsp_power_value)
   );

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      front_push |-> !queue_full)
      else $error("frame job pushed into a full queue");

   a_mismatch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_status) |->
         (rsp_voltage_value == '0 && rsp_current_value == '0 && rsp_power_value == '0))
      else $error("checksum mismatch response carries nonzero values");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (!bk_status.busy && queue_empty && !rsp_valid) |=> !rsp_valid)
      else $error("response appeared with no job pending");

endmodule

`default_nettype wire
